// ===== rtl/sbau_pkg.sv =====
// Package for the signed BCD arithmetic unit: digit constants, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
package sbau_pkg;
	localparam int DIGITS_DEF = 30;
	localparam int FIELD_DIGITS = 30;
	localparam int LOW_DIGITS = 16;
	localparam int LOW_W = 64;
	localparam int HIGH_W = 56;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;
	localparam logic [1:0] ST_BAD  = 2'd3;

	// one BCD digit plus carry: s is 0..19 -> digit and carry
	function automatic logic [4:0] bcd_add(input logic [3:0] x, input logic [3:0] y,
		input logic ci);
		logic [4:0] s;
		begin
			s = {1'b0, x} + {1'b0, y} + {4'b0, ci};
			if (s > 5'd9) bcd_add = {1'b1, 4'(s - 5'd10)};
			else bcd_add = {1'b0, s[3:0]};
		end
	endfunction

	// x - y - bi, returns {borrow, digit}
	function automatic logic [4:0] bcd_sub(input logic [3:0] x, input logic [3:0] y,
		input logic bi);
		logic [5:0] v;
		begin
			v = {2'b0, x} - {2'b0, y} - {5'b0, bi};
			if (v[5]) bcd_sub = {1'b1, 4'(v[3:0] + 4'd10)};
			else bcd_sub = {1'b0, v[3:0]};
		end
	endfunction
endpackage

// ===== rtl/signed_bcd_arith_unit.sv =====
// Signed-magnitude BCD arithmetic unit, top level and only module.
// Depends on sbau_pkg.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_ready) carries func, two signed-magnitude BCD
//  operands split into low and high digit words. Output channel
//  (out_valid/out_ready) carries the result, remainder and status.
//  One word is worked at a time; in_ready is high only when the unit is idle.
//  Every operation runs through digit-serial rotating registers, one BCD
//  digit per cycle through the BCD digit adder and subtractor functions. An
//  accepted word gets a digit check pass and a setup step (N = DIGITS),
//  then:
//   bad operand, zero divisor: straight to pack
//   add/sub : one add or subtract pass over N digits
//   multiply: per digit d of b, a shift and d add passes
//   divide  : per quotient digit q, a shift and q+1 trial subtract passes
//  and a final pack step before out_valid. A finished result is held in
//  the output registers until taken; a stalled receiver holds the unit.
//  After the result is taken the next word is accepted in the following
//  cycle at the earliest. Reset clears the control state only; the unit
//  keeps no state between words.
module signed_bcd_arith_unit
	import sbau_pkg::*;
#(
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  logic [LOW_W-1:0]    a_low_digits,
	input  logic [HIGH_W-1:0]   a_high_digits,
	input  logic                a_negative,
	input  logic [LOW_W-1:0]    b_low_digits,
	input  logic [HIGH_W-1:0]   b_high_digits,
	input  logic                b_negative,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LOW_W-1:0]    result_low_digits,
	output logic [HIGH_W-1:0]   result_high_digits,
	output logic                result_negative,
	output logic [LOW_W-1:0]    remainder_low_digits,
	output logic [HIGH_W-1:0]   remainder_high_digits,
	output logic [1:0]          status
);
	localparam int ND = (DIGITS < FIELD_DIGITS) ? DIGITS : FIELD_DIGITS;
	localparam int W = 4 * ND;
	localparam int WR = 4 * (ND + 1);
	localparam int CW = $clog2(ND + 2);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_CMP   = 4'd2;
	localparam logic [3:0] S_AS    = 4'd3;
	localparam logic [3:0] S_MSEL  = 4'd4;
	localparam logic [3:0] S_MADD  = 4'd5;
	localparam logic [3:0] S_MSH   = 4'd6;
	localparam logic [3:0] S_DSH   = 4'd7;
	localparam logic [3:0] S_DSUB  = 4'd8;
	localparam logic [3:0] S_PACK  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] state_q;
	logic [1:0] func_q;
	logic an_q, bn_q, neg_q, bad_q, bz_q, ovf_q, swap_q, gt_q, lt_q, carry_q;
	// a_q: operand a / multiplicand / dividend; b_q: operand b / multiplier digits / divisor
	logic [W-1:0] a_q, b_q, acc_q, res_q;
	logic [WR-1:0] rem_q, tr_q;
	logic [CW-1:0] dcnt_q, pcnt_q;
	logic [3:0] qd_q;
	logic [LOW_W-1:0] rlo_q, mlo_q;
	logic [HIGH_W-1:0] rhi_q, mhi_q;
	logic [1:0] st_q;

	logic [W-1:0] a_in, b_in;
	logic [4:0] add_o, sub_o, dsub_o;
	logic [3:0] ax, bx;
	logic bad_d;

	// gather the used digits from the split fields
	always_comb begin
		logic [4*FIELD_DIGITS-1:0] fa, fb;
		fa = {a_high_digits, a_low_digits};
		fb = {b_high_digits, b_low_digits};
		a_in = fa[W-1:0];
		b_in = fb[W-1:0];
	end

	assign ax = a_q[3:0];
	assign bx = b_q[3:0];
	assign add_o = bcd_add(ax, bx, carry_q);
	assign sub_o = swap_q ? bcd_sub(bx, ax, carry_q) : bcd_sub(ax, bx, carry_q);
	assign dsub_o = bcd_sub(tr_q[3:0], (dcnt_q == CW'(ND)) ? 4'd0 : bx, carry_q);
	assign bad_d = (ax > 4'd9) || (bx > 4'd9);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign result_low_digits = rlo_q;
	assign result_high_digits = rhi_q;
	assign remainder_low_digits = mlo_q;
	assign remainder_high_digits = mhi_q;
	assign result_negative = neg_q;
	assign status = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHK;
						func_q <= func;
						an_q <= a_negative;
						bn_q <= b_negative;
						a_q <= a_in;
						b_q <= b_in;
						bad_q <= 1'b0;
						bz_q <= 1'b1;
						gt_q <= 1'b0;
						lt_q <= 1'b0;
						dcnt_q <= '0;
					end
				end
				// rotate both operands once: digit check, zero test, magnitude compare
				S_CHK: begin
					a_q <= {ax, a_q[W-1:4]};
					b_q <= {bx, b_q[W-1:4]};
					if (bad_d) bad_q <= 1'b1;
					if (bx != 4'd0) bz_q <= 1'b0;
					// later digits dominate
					if (ax > bx) begin
						gt_q <= 1'b1; lt_q <= 1'b0;
					end else if (ax < bx) begin
						gt_q <= 1'b0; lt_q <= 1'b1;
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == CW'(ND - 1)) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					dcnt_q <= '0;
					carry_q <= 1'b0;
					acc_q <= '0;
					res_q <= '0;
					rem_q <= '0;
					ovf_q <= 1'b0;
					if (bad_q) begin
						st_q <= ST_BAD;
						neg_q <= 1'b0;
						state_q <= S_PACK;
					end else if (func_q inside {FUNC_ADD, FUNC_SUB}) begin
						logic ebn;
						ebn = (func_q == FUNC_SUB) ? !bn_q : bn_q;
						st_q <= ST_OK;
						if (an_q == ebn) begin
							swap_q <= 1'b0;
							neg_q <= an_q;
							gt_q <= 1'b1; // mark add
						end else begin
							// pos - neg; pos is a when an=0
							logic pos_ge;
							pos_ge = an_q ? !gt_q : !lt_q;
							swap_q <= an_q ^ !pos_ge;
							neg_q <= !pos_ge;
							gt_q <= 1'b0;
						end
						state_q <= S_AS;
					end else if (func_q == FUNC_MUL) begin
						st_q <= ST_OK;
						neg_q <= an_q ^ bn_q;
						swap_q <= 1'b0;
						pcnt_q <= '0;
						state_q <= S_MSEL;
					end else begin
						neg_q <= 1'b0;
						if (an_q || bn_q) begin
							st_q <= ST_BAD;
							state_q <= S_PACK;
						end else if (bz_q) begin
							st_q <= ST_DIV0;
							state_q <= S_PACK;
						end else begin
							st_q <= ST_OK;
							pcnt_q <= '0;
							state_q <= S_DSH;
						end
					end
				end
				// add (acc = a + b) or subtract (res = larger - smaller), a digit a cycle
				S_AS: begin
					a_q <= {ax, a_q[W-1:4]};
					b_q <= {bx, b_q[W-1:4]};
					if (gt_q) begin
						acc_q <= {add_o[3:0], acc_q[W-1:4]};
						carry_q <= add_o[4];
					end else begin
						acc_q <= {sub_o[3:0], acc_q[W-1:4]};
						carry_q <= sub_o[4];
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == CW'(ND - 1)) begin
						logic c;
						c = gt_q ? add_o[4] : 1'b0;
						res_q <= gt_q ? {add_o[3:0], acc_q[W-1:4]} : {sub_o[3:0], acc_q[W-1:4]};
						if (c) st_q <= ST_OVF;
						state_q <= S_PACK;
					end
				end
				// multiply: a_q holds multiplicand, b digits are taken from the top of b_q.
				// Process b digits from most significant: acc = acc*10 + a*digit.
				S_MSEL: begin
					// top digit of b selects the number of add passes
					qd_q <= b_q[W-1 -: 4];
					b_q <= {b_q[W-5:0], 4'd0};
					dcnt_q <= '0;
					carry_q <= 1'b0;
					state_q <= S_MSH;
				end
				// shift acc up one digit (times ten); a lost digit is overflow
				S_MSH: begin
					if (acc_q[W-1 -: 4] != 4'd0) ovf_q <= 1'b1;
					acc_q <= {acc_q[W-5:0], 4'd0};
					state_q <= S_MADD;
				end
				// one serial pass of acc += a while add passes remain for this digit of b
				S_MADD: begin
					if (qd_q == 4'd0) begin
						pcnt_q <= pcnt_q + 1'b1;
						if (pcnt_q == CW'(ND - 1)) begin
							res_q <= acc_q;
							state_q <= S_PACK;
						end else begin
							state_q <= S_MSEL;
						end
					end else begin
						logic [4:0] s;
						s = bcd_add(acc_q[3:0], ax, carry_q);
						a_q <= {ax, a_q[W-1:4]};
						acc_q <= {s[3:0], acc_q[W-1:4]};
						if (dcnt_q == CW'(ND - 1)) begin
							if (s[4]) ovf_q <= 1'b1;
							carry_q <= 1'b0;
							dcnt_q <= '0;
							qd_q <= qd_q - 4'd1;
						end else begin
							carry_q <= s[4];
							dcnt_q <= dcnt_q + 1'b1;
						end
					end
				end
				// divide: bring next dividend digit into the remainder
				S_DSH: begin
					rem_q <= {rem_q[WR-5:0], a_q[W-1 -: 4]};
					a_q <= {a_q[W-5:0], 4'd0};
					tr_q <= {rem_q[WR-5:0], a_q[W-1 -: 4]};
					qd_q <= 4'd0;
					dcnt_q <= '0;
					carry_q <= 1'b0;
					state_q <= S_DSUB;
				end
				// trial subtract tr = rem - b serially over ND+1 digits
				S_DSUB: begin
					if (dcnt_q == CW'(ND)) begin
						logic [WR-1:0] t;
						t = {dsub_o[3:0], tr_q[WR-1:4]};
						dcnt_q <= '0;
						carry_q <= 1'b0;
						if (!dsub_o[4] && qd_q != 4'd9) begin
							rem_q <= t;
							tr_q <= t;
							qd_q <= qd_q + 4'd1;
						end else begin
							res_q <= {res_q[W-5:0], qd_q};
							tr_q <= rem_q;
							pcnt_q <= pcnt_q + 1'b1;
							if (pcnt_q == CW'(ND - 1)) state_q <= S_PACK;
							else state_q <= S_DSH;
						end
					end else begin
						tr_q <= {dsub_o[3:0], tr_q[WR-1:4]};
						b_q <= {bx, b_q[W-1:4]};
						carry_q <= dsub_o[4];
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
				S_PACK: begin
					logic [4*FIELD_DIGITS-1:0] r, m;
					r = '0;
					m = '0;
					if (st_q inside {ST_OK, ST_OVF}) begin
						r[W-1:0] = res_q;
						if (func_q == FUNC_DIV) m[W-1:0] = rem_q[W-1:0];
					end
					rlo_q <= r[LOW_W-1:0];
					rhi_q <= r[4*FIELD_DIGITS-1:LOW_W];
					mlo_q <= m[LOW_W-1:0];
					mhi_q <= m[4*FIELD_DIGITS-1:LOW_W];
					if (func_q == FUNC_MUL && ovf_q && st_q == ST_OK) st_q <= ST_OVF;
					if (st_q inside {ST_BAD, ST_DIV0} || func_q == FUNC_DIV) neg_q <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
